@@ sv/byte_memory_multiwidth_access_assert.svh @@
// Assertion macros used by the byte memory RTL.
`ifndef BYTE_MEMORY_MULTIWIDTH_ACCESS_ASSERT_SVH
`define BYTE_MEMORY_MULTIWIDTH_ACCESS_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define BMA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define BMA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/bma_pkg.sv @@
`default_nettype none

package bma_pkg;

    // Access direction
    localparam logic MODE_READ  = 1'b0;
    localparam logic MODE_WRITE = 1'b1;

    // Access width codes
    localparam logic [1:0] WCODE_BYTE = 2'd0;
    localparam logic [1:0] WCODE_HALF = 2'd1;
    localparam logic [1:0] WCODE_WORD = 2'd2;
    localparam logic [1:0] WCODE_BAD  = 2'd3;

    // Width of a byte index that covers the largest supported store
    localparam int IDX_W = 20;

    // Command to one byte bank
    typedef struct packed {
        logic       en;
        logic       we;
        logic [7:0] wdata;
    } bank_cmd_t;

endpackage

`default_nettype wire

@@ sv/byte_memory_multiwidth_access.sv @@
// A result strobes on done in the cycle after the access is taken.
// Throughput: one access per cycle while busy is low; each byte bank sees at most one row per access.
// Reset: the size register returns to 65536 and the store is zeroed by a clearing pass
// over every bank row, during which busy is high and no access is taken.
// Results are never stalled: done is a one-cycle strobe.
`default_nettype none

module byte_memory_multiwidth_access
    import bma_pkg::*;
#(
    parameter int MEM_BYTES = 65536
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        mode,
    input  wire logic [1:0]  access_width,
    input  wire logic [15:0] address,
    input  wire logic [31:0] write_value,
    input  wire logic        msb_first,
    output logic             done,
    output logic      [31:0] read_value,
    output logic             out_of_range,
    input  wire logic        cfg_we,
    input  wire logic [16:0] size_in_use
);

    localparam int ROWS = (MEM_BYTES + 3) / 4;
    localparam int RAW  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam logic [20:0]    MEM_LIM  = 21'(MEM_BYTES);
    localparam logic [RAW-1:0] ROW_LAST = RAW'(ROWS - 1);

    logic [16:0]    size_reg;
    logic           clr_active_reg;
    logic [RAW-1:0] clr_row_reg;

    logic           done_reg;
    logic           err_reg;
    logic           rd_ok_reg;
    logic [1:0]     a0_reg;
    logic           msb_reg;
    logic [2:0]     nbytes_reg;

    logic           accept;
    logic [2:0]     nbytes;
    logic [20:0]    end_sum;
    logic [20:0]    size_ext;
    logic [20:0]    eff_size;
    logic           err;

    bank_cmd_t      cmd     [4];
    logic [RAW-1:0] row     [4];
    logic [7:0]     rdata   [4];
    logic [31:0]    rd_word;

    assign accept = start && !clr_active_reg;
    assign busy   = clr_active_reg;

    // Hold the size register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= 17'h10000;
        end
        else if (cfg_we)
        begin
            size_reg <= size_in_use;
        end
    end

    // Sweep the banks once after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_row_reg    <= '0;
        end
        else if (clr_active_reg)
        begin
            if (clr_row_reg == ROW_LAST)
            begin
                clr_active_reg <= 1'b0;
            end
            else
            begin
                clr_row_reg <= clr_row_reg + 1'b1;
            end
        end
    end

    // Decode width and check range
    always_comb
    begin
        case (access_width)
            WCODE_BYTE: nbytes = 3'd1;
            WCODE_HALF: nbytes = 3'd2;
            WCODE_WORD: nbytes = 3'd4;
            default:    nbytes = 3'd0;
        endcase
        end_sum  = {5'b0, address} + {18'b0, nbytes};
        size_ext = {4'b0, size_reg};
        eff_size = (size_ext > MEM_LIM) ? MEM_LIM : size_ext;
        err      = (access_width == WCODE_BAD) || (end_sum > eff_size);
    end

    // Steer each byte lane to its bank and row
    always_comb
    begin
        logic [1:0]       off;
        logic [1:0]       nm1;
        logic [1:0]       rank;
        logic             used;
        logic [IDX_W-1:0] idx;
        nm1 = 2'(nbytes - 3'd1);
        for (int b = 0; b < 4; b++)
        begin
            off  = 2'(b) - address[1:0];
            used = ({1'b0, off} < nbytes);
            rank = msb_first ? (nm1 - off) : off;
            idx  = {4'b0, address} + {18'b0, off};
            if (clr_active_reg)
            begin
                cmd[b].en    = 1'b1;
                cmd[b].we    = 1'b1;
                cmd[b].wdata = 8'h00;
                row[b]       = clr_row_reg;
            end
            else
            begin
                cmd[b].en    = accept && !err && used;
                cmd[b].we    = (mode == MODE_WRITE);
                cmd[b].wdata = write_value[{rank, 3'b000} +: 8];
                row[b]       = idx[RAW+1:2];
            end
        end
    end

    // Byte banks, interleaved on the low address bits
    for (genvar g = 0; g < 4; g++)
    begin : g_bank
        bma_bank #(
            .ROWS (ROWS),
            .RAW  (RAW)
        ) u_bank (
            .clk   (clk),
            .cmd   (cmd[g]),
            .addr  (row[g]),
            .rdata (rdata[g])
        );
    end

    // Track the access while the banks read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg  <= 1'b0;
            rd_ok_reg <= 1'b0;
        end
        else
        begin
            done_reg  <= accept;
            rd_ok_reg <= accept && !err && (mode == MODE_READ);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            err_reg    <= err;
            a0_reg     <= address[1:0];
            msb_reg    <= msb_first;
            nbytes_reg <= nbytes;
        end
    end

    // Assemble the read word from the bank outputs
    always_comb
    begin
        logic [1:0] bank;
        logic [1:0] nm1;
        logic [1:0] rank;
        rd_word = '0;
        nm1     = 2'(nbytes_reg - 3'd1);
        for (int i = 0; i < 4; i++)
        begin
            bank = a0_reg + 2'(i);
            rank = msb_reg ? (nm1 - 2'(i)) : 2'(i);
            if (3'(i) < nbytes_reg)
            begin
                rd_word[{rank, 3'b000} +: 8] = rdata[bank];
            end
        end
    end

    assign done         = done_reg;
    assign read_value   = rd_ok_reg ? rd_word : 32'h0;
    assign out_of_range = done_reg && err_reg;

`include "byte_memory_multiwidth_access_assert.svh"

    `BMA_ASSERT_NEXT(a_done_follows, start && !busy, done, "accepted access gave no result")
    `BMA_ASSERT_NOW(a_done_has_cause, done, $past(start && !busy), "result without access")
    `BMA_ASSERT_NOW(a_err_reads_zero, done && out_of_range, read_value == 32'h0, "data on error")

endmodule

`default_nettype wire

@@ sv/bma_bank.sv @@
`default_nettype none

module bma_bank
    import bma_pkg::*;
#(
    parameter int ROWS = 16384,
    parameter int RAW  = 14
) (
    input  wire logic            clk,
    input  wire bank_cmd_t       cmd,
    input  wire logic [RAW-1:0]  addr,
    output logic      [7:0]      rdata
);

    logic [7:0] mem [ROWS];
    logic [7:0] rdata_reg;

    // Single port: write or registered read
    always_ff @(posedge clk)
    begin
        if (cmd.en)
        begin
            if (cmd.we)
            begin
                mem[addr] <= cmd.wdata;
            end
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ sim/tb_byte_memory_multiwidth_access.sv @@
`default_nettype none

module tb_byte_memory_multiwidth_access;
    import bma_pkg::*;

    localparam int unsigned STORE_BYTES = 65536;
    localparam logic [16:0] SIZE_FULL   = 17'h10000;
    localparam logic [16:0] SIZE_TOP    = 17'h1FFFF;
    localparam int          PRINT_LIMIT = 20;

    typedef struct packed {
        logic [31:0] value;
        logic        oor;
    } access_result_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        mode;
    logic [1:0]  access_width;
    logic [15:0] address;
    logic [31:0] write_value;
    logic        msb_first;
    logic        done;
    logic [31:0] read_value;
    logic        out_of_range;
    logic        cfg_we;
    logic [16:0] size_in_use;

    // Shadow copy of the byte store and the size register
    logic [7:0]     shadow_store [0:STORE_BYTES-1];
    logic [16:0]    shadow_size;
    access_result_t pending_results [$];
    int             mismatch_count;
    int unsigned    gap_pct;

    byte_memory_multiwidth_access dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .mode         (mode),
        .access_width (access_width),
        .address      (address),
        .write_value  (write_value),
        .msb_first    (msb_first),
        .done         (done),
        .read_value   (read_value),
        .out_of_range (out_of_range),
        .cfg_we       (cfg_we),
        .size_in_use  (size_in_use)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #3000000;
        $display("TB_ERROR");
        $finish;
    end

    // Apply one access to the shadow store and return the beat it should produce
    function automatic access_result_t predict_access(logic m, logic [1:0] wc, logic [15:0] a,
                                                      logic [31:0] wv, logic msb);
        access_result_t r;
        int unsigned    reach;
        int unsigned    nbytes;
        int unsigned    rank;
        int unsigned    i;
        r = '0;
        reach = (shadow_size > SIZE_FULL) ? STORE_BYTES : int'(shadow_size);
        if (wc == WCODE_BAD)
        begin
            r.oor = 1'b1;
            return r;
        end
        nbytes = 1 << wc;
        if (int'(a) + nbytes > reach)
        begin
            r.oor = 1'b1;
            return r;
        end
        for (i = 0; i < nbytes; i++)
        begin
            rank = msb ? (nbytes - 1 - i) : i;
            if (m == MODE_WRITE)
                shadow_store[int'(a) + i] = wv[rank*8 +: 8];
            else
                r.value[rank*8 +: 8] = shadow_store[int'(a) + i];
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("mismatch at %0t: %s expected %h got %h", $realtime, what, want, got);
    endtask

    // Compare each result beat with the oldest pending prediction
    always @(posedge clk)
    begin : check_results
        access_result_t want;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result with none pending", 32'h0, read_value);
            else
            begin
                want = pending_results.pop_front();
                if (read_value !== want.value)
                    report_mismatch("read_value", want.value, read_value);
                if (out_of_range !== want.oor)
                    report_mismatch("out_of_range", {31'h0, want.oor}, {31'h0, out_of_range});
            end
        end
    end

    // Drive one access, hold it until taken, then record its prediction
    task automatic send_access(logic m, logic [1:0] wc, logic [15:0] a, logic [31:0] wv,
                               logic msb);
        if (gap_pct != 0 && $urandom_range(99) < gap_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        start        <= 1'b1;
        mode         <= m;
        access_width <= wc;
        address      <= a;
        write_value  <= wv;
        msb_first    <= msb;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_results.push_back(predict_access(m, wc, a, wv, msb));
    endtask

    // Drop start and wait until every pending beat has come back
    task automatic drain_results();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic set_size(logic [16:0] value);
        drain_results();
        cfg_we      <= 1'b1;
        size_in_use <= value;
        @(posedge clk);
        cfg_we      <= 1'b0;
        shadow_size = value;
        @(posedge clk);
    endtask

    task automatic test_directed_accesses();
        gap_pct = 0;
        // Word round trip in both byte orders, then narrow reads of it
        send_access(MODE_WRITE, WCODE_WORD, 16'h0000, 32'h11223344, 1'b1);
        send_access(MODE_READ,  WCODE_WORD, 16'h0000, 32'h0, 1'b1);
        send_access(MODE_READ,  WCODE_WORD, 16'h0000, 32'h0, 1'b0);
        send_access(MODE_READ,  WCODE_HALF, 16'h0001, 32'h0, 1'b0);
        send_access(MODE_READ,  WCODE_BYTE, 16'h0003, 32'h0, 1'b1);
        // Top of the store: last fitting word, accesses that spill over, then a last byte that fits
        send_access(MODE_WRITE, WCODE_WORD, 16'hFFFC, 32'hFFFFFFFF, 1'b0);
        send_access(MODE_READ,  WCODE_WORD, 16'hFFFC, 32'h0, 1'b1);
        send_access(MODE_WRITE, WCODE_WORD, 16'hFFFD, 32'h55AA55AA, 1'b0);
        send_access(MODE_READ,  WCODE_HALF, 16'hFFFF, 32'h0, 1'b0);
        send_access(MODE_WRITE, WCODE_BYTE, 16'hFFFF, 32'hFFFFFFA5, 1'b1);
        send_access(MODE_READ,  WCODE_BYTE, 16'hFFFF, 32'h0, 1'b0);
        // Undefined width code is rejected and leaves the store alone
        send_access(MODE_WRITE, WCODE_BAD,  16'h0000, 32'hFFFFFFFF, 1'b1);
        send_access(MODE_READ,  WCODE_BAD,  16'h0000, 32'h0, 1'b0);
        send_access(MODE_READ,  WCODE_WORD, 16'h0000, 32'h0, 1'b0);
        // Unaligned half across a row boundary, then zero write over it
        send_access(MODE_WRITE, WCODE_HALF, 16'h7FFF, 32'hDEADBEEF, 1'b1);
        send_access(MODE_READ,  WCODE_WORD, 16'h7FFE, 32'h0, 1'b0);
        send_access(MODE_WRITE, WCODE_WORD, 16'h7FFF, 32'h00000000, 1'b0);
        send_access(MODE_READ,  WCODE_WORD, 16'h7FFD, 32'h0, 1'b1);
    endtask

    task automatic test_size_extremes();
        gap_pct = 0;
        // Zero size rejects everything
        set_size(17'd0);
        send_access(MODE_WRITE, WCODE_BYTE, 16'h0000, 32'h000000FF, 1'b0);
        send_access(MODE_READ,  WCODE_WORD, 16'h0000, 32'h0, 1'b1);
        // One byte: only a single byte at zero fits
        set_size(17'd1);
        send_access(MODE_READ,  WCODE_BYTE, 16'h0000, 32'h0, 1'b0);
        send_access(MODE_READ,  WCODE_HALF, 16'h0000, 32'h0, 1'b0);
        // Four bytes: one word at zero fits, shifted by one it does not
        set_size(17'd4);
        send_access(MODE_WRITE, WCODE_WORD, 16'h0000, 32'hCAFEF00D, 1'b0);
        send_access(MODE_READ,  WCODE_WORD, 16'h0001, 32'h0, 1'b0);
        send_access(MODE_READ,  WCODE_BYTE, 16'h0003, 32'h0, 1'b1);
        // Size above the store acts as the full store
        set_size(SIZE_TOP);
        send_access(MODE_READ,  WCODE_WORD, 16'hFFFC, 32'h0, 1'b0);
        send_access(MODE_READ,  WCODE_BYTE, 16'hFFFF, 32'h0, 1'b1);
        send_access(MODE_READ,  WCODE_WORD, 16'hFFFD, 32'h0, 1'b1);
    endtask

    // Mostly clustered traffic so reads hit earlier writes, plus boundary and noise beats
    task automatic run_random_phase(logic [16:0] size_value, int unsigned pct, int count);
        int unsigned reach;
        int unsigned base;
        int unsigned pick;
        int unsigned k;
        int unsigned a;
        logic [1:0]  wc;
        int          n;
        set_size(size_value);
        gap_pct = pct;
        reach = (shadow_size > SIZE_FULL) ? STORE_BYTES : int'(shadow_size);
        base = 0;
        for (n = 0; n < count; n++)
        begin
            if (n % 50 == 0)
                base = $urandom_range((reach > 32) ? reach - 32 : 0);
            pick = $urandom_range(99);
            wc = 2'($urandom_range(2));
            if (pick < 8)
            begin
                wc = 2'($urandom_range(3));
                a = $urandom_range(65535);
            end
            else if (pick < 23)
            begin
                k = $urandom_range(5);
                a = (reach > 5) ? reach - 1 - k : k;
            end
            else
                a = base + $urandom_range(31);
            send_access(1'($urandom_range(1)), wc, 16'(a), $urandom(), 1'($urandom_range(1)));
        end
    endtask

    task automatic test_random_traffic();
        run_random_phase(SIZE_FULL, 0, 455);
        run_random_phase(17'($urandom_range(1000, 65535)), 53, 455);
        run_random_phase(SIZE_TOP, 0, 455);
        run_random_phase(17'($urandom_range(2, 48)), 22, 455);
    endtask

    initial
    begin
        int unsigned i;
        for (i = 0; i < STORE_BYTES; i++)
            shadow_store[i] = 8'h00;
        shadow_size    = SIZE_FULL;
        mismatch_count = 0;
        gap_pct        = 0;
        rst_n          <= 1'b0;
        start          <= 1'b0;
        mode           <= MODE_READ;
        access_width   <= WCODE_BYTE;
        address        <= 16'h0000;
        write_value    <= 32'h0;
        msb_first      <= 1'b0;
        cfg_we         <= 1'b0;
        size_in_use    <= SIZE_FULL;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        // Wait out the clearing pass
        repeat (2) @(posedge clk);
        while (busy)
            @(posedge clk);

        test_directed_accesses();
        test_size_extremes();
        test_random_traffic();
        drain_results();

        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire

@@ byte_memory_multiwidth_access.f @@
+incdir+sv
sv/bma_pkg.sv
sv/bma_bank.sv
sv/byte_memory_multiwidth_access.sv
sim/tb_byte_memory_multiwidth_access.sv
